// ===== rtl/modular_exponentiation_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the modular exponentiation block
// Shared concurrent-assertion shorthands, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef MODULAR_EXPONENTIATION_DEFINES_SVH
`define MODULAR_EXPONENTIATION_DEFINES_SVH

// ante must be followed by cons in the same cycle
`define MEXP_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// ante must be followed by cons in the next cycle
`define MEXP_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/mexp_pkg.sv =====
// ----------------------------------------------------------------------------
// mexp_pkg
// Types and fixed constants of the modular exponentiation block.
// ----------------------------------------------------------------------------
package mexp_pkg;

  localparam int unsigned ResW     = 30;
  localparam int unsigned BaseW    = 63;
  localparam int unsigned BaseCntW = $clog2(BaseW);
  localparam int unsigned MulCntW  = $clog2(ResW);

  // modulus, below 2^30
  localparam logic [ResW-1:0] Prime = 30'd1000000007;

  typedef enum logic [1:0] {
    StIdle,
    StReduce,
    StLoop,
    StMul
  } state_e;

endpackage

// ===== rtl/mexp_mulmod.sv =====
// ----------------------------------------------------------------------------
// mexp_mulmod
// Bit-serial modular multiplier: one multiplier bit per cycle, MSB first.
// ----------------------------------------------------------------------------
`include "modular_exponentiation_defines.svh"

module mexp_mulmod (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [mexp_pkg::ResW-1:0]   a_i,
  input  logic [mexp_pkg::ResW-1:0]   b_i,
  output logic                        done_o,
  output logic [mexp_pkg::ResW-1:0]   prod_o
);

  localparam int unsigned W = mexp_pkg::ResW;
  localparam logic [W+1:0] P1 = {2'b00, mexp_pkg::Prime};
  localparam logic [W+1:0] P2 = {1'b0, mexp_pkg::Prime, 1'b0};

  logic                        busy_q, busy_d;
  logic                        done_q, done_d;
  logic [mexp_pkg::MulCntW-1:0] cnt_q, cnt_d;
  logic [W-1:0]                a_q, a_d;
  logic [W-1:0]                b_q, b_d;
  logic [W-1:0]                r_q, r_d;
  logic [W+1:0]                sum;
  logic [W+1:0]                red;

  // r = 2r + bit*a, then fold back below p (sum < 3p)
  always_comb begin
    sum = {1'b0, r_q, 1'b0} + (b_q[W-1] ? {2'b00, a_q} : '0);
    priority if (sum >= P2) begin
      red = sum - P2;
    end else if (sum >= P1) begin
      red = sum - P1;
    end else begin
      red = sum;
    end
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    a_d    = a_q;
    b_d    = b_q;
    r_d    = r_q;
    if (start_i && !busy_q) begin
      busy_d = 1'b1;
      cnt_d  = mexp_pkg::MulCntW'(W - 1);
      a_d    = a_i;
      b_d    = b_i;
      r_d    = '0;
    end else if (busy_q) begin
      r_d = red[W-1:0];
      b_d = {b_q[W-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    b_q <= b_d;
    r_q <= r_d;
  end

  assign done_o = done_q;
  assign prod_o = r_q;

  `MEXP_ASSERT_NXT(a_mm_start, clk_i, rst_ni, start_i && !busy_q, busy_q, "mulmod did not start")
  `MEXP_ASSERT_NXT(a_mm_done_pulse, clk_i, rst_ni, done_q, !done_q, "mulmod done held")
  `MEXP_ASSERT_IMP(a_mm_done_idle, clk_i, rst_ni, done_q, !busy_q, "mulmod done while busy")

endmodule

// ===== rtl/modular_exponentiation.sv =====
// ----------------------------------------------------------------------------
// modular_exponentiation
// base^exponent mod 1000000007, right-to-left square-and-multiply, bit-serial.
// ----------------------------------------------------------------------------
// Pulse start while busy is low; base and exponent are sampled on that edge.
// The result comes back on result_o for exactly one cycle with done_o high;
// there is no backpressure, so capture it then. From the accepting edge the
// base is first reduced (one base bit per cycle), then the exponent is
// tested, and for each exponent bit up to the highest set bit two bit-serial
// modular multipliers run side by side (square and conditional product)
// before the next test. With an exponent of zero the result, one, is shown
// straight after the first test. busy drops in the cycle done_o is shown, so
// the next word may be issued right away.
// ----------------------------------------------------------------------------
`include "modular_exponentiation_defines.svh"

module modular_exponentiation #(
  parameter int unsigned EXP_BITS = 63
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [mexp_pkg::BaseW-1:0]    base_value_i,
  input  logic [62:0]                   exponent_i,
  output logic                          done_o,
  output logic [mexp_pkg::ResW-1:0]     result_o
);

  localparam int unsigned W  = mexp_pkg::ResW;
  localparam int unsigned BW = mexp_pkg::BaseW;

  mexp_pkg::state_e state_q, state_d;

  logic [BW-1:0]                 base_q, base_d;     // base, shifted out MSB first
  logic [mexp_pkg::BaseCntW-1:0] cnt_q, cnt_d;
  logic [W-1:0]                  sq_q, sq_d;         // current square
  logic [W-1:0]                  acc_q, acc_d;       // running product
  logic [EXP_BITS-1:0]           exp_q, exp_d;       // remaining exponent bits
  logic [W-1:0]                  result_q, result_d;
  logic                          done_q, done_d;

  logic                          mul_start;
  logic                          sq_done, acc_done;
  logic [W-1:0]                  sq_prod, acc_prod;
  logic [W:0]                    red_sum;
  logic [W-1:0]                  red_next;

  // one reduction step: r = 2r + bit, minus p if it overflows
  always_comb begin
    red_sum = {sq_q, base_q[BW-1]};
    if (red_sum >= {1'b0, mexp_pkg::Prime}) begin
      red_next = W'(red_sum - {1'b0, mexp_pkg::Prime});
    end else begin
      red_next = red_sum[W-1:0];
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mexp_pkg::StIdle: begin
        if (start) state_d = mexp_pkg::StReduce;
      end
      mexp_pkg::StReduce: begin
        if (cnt_q == '0) state_d = mexp_pkg::StLoop;
      end
      mexp_pkg::StLoop: begin
        state_d = (exp_q == '0) ? mexp_pkg::StIdle : mexp_pkg::StMul;
      end
      mexp_pkg::StMul: begin
        if (sq_done) state_d = mexp_pkg::StLoop;
      end
      default: state_d = mexp_pkg::StIdle;
    endcase
  end

  // outputs and datapath
  always_comb begin
    busy      = (state_q != mexp_pkg::StIdle);
    mul_start = 1'b0;
    base_d    = base_q;
    cnt_d     = cnt_q;
    sq_d      = sq_q;
    acc_d     = acc_q;
    exp_d     = exp_q;
    result_d  = result_q;
    done_d    = 1'b0;
    unique case (state_q)
      mexp_pkg::StIdle: begin
        if (start) begin
          base_d = base_value_i;
          exp_d  = exponent_i[EXP_BITS-1:0];
          cnt_d  = mexp_pkg::BaseCntW'(BW - 1);
          sq_d   = '0;
          acc_d  = W'(1);
        end
      end
      mexp_pkg::StReduce: begin
        sq_d   = red_next;
        base_d = {base_q[BW-2:0], 1'b0};
        cnt_d  = cnt_q - 1'b1;
      end
      mexp_pkg::StLoop: begin
        if (exp_q == '0) begin
          result_d = acc_q;
          done_d   = 1'b1;
        end else begin
          mul_start = 1'b1;
        end
      end
      mexp_pkg::StMul: begin
        if (sq_done) begin
          sq_d  = sq_prod;
          if (exp_q[0]) acc_d = acc_prod;
          exp_d = exp_q >> 1;
        end
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mexp_pkg::StIdle;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q   <= base_d;
    sq_q     <= sq_d;
    acc_q    <= acc_d;
    exp_q    <= exp_d;
    result_q <= result_d;
  end

  // square and product multipliers run in lockstep
  mexp_mulmod u_mul_sq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (sq_q),
    .b_i     (sq_q),
    .done_o  (sq_done),
    .prod_o  (sq_prod)
  );

  mexp_mulmod u_mul_acc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (sq_q),
    .b_i     (acc_q),
    .done_o  (acc_done),
    .prod_o  (acc_prod)
  );

  assign done_o   = done_q;
  assign result_o = result_q;

  `MEXP_ASSERT_IMP(a_mul_lockstep, clk_i, rst_ni, 1'b1, sq_done == acc_done, "multipliers out of step")
  `MEXP_ASSERT_IMP(a_result_range, clk_i, rst_ni, done_o, result_o < mexp_pkg::Prime, "result not reduced")
  `MEXP_ASSERT_NXT(a_accept_busy, clk_i, rst_ni, start && !busy, busy, "accepted word not in flight")
  `MEXP_ASSERT_NXT(a_done_pulse, clk_i, rst_ni, done_o, !done_o, "done held over two cycles")

endmodule

// ===== sim/tb_modular_exponentiation.sv =====
// ----------------------------------------------------------------------------
// tb_modular_exponentiation
// Self-checking bench for base^exponent mod 1000000007.
// ----------------------------------------------------------------------------
// A short table of corner words comes first: zero exponent, zero base,
// multiples of the prime, all-ones fields and Fermat's little theorem. Then
// about a thousand random words follow. Most of them have short exponents to
// keep the run fast, and some have full 63-bit exponents. Every result is
// checked in order, against the value typed into the table where there is
// one and else against a square-and-multiply predictor that runs in the bench.
// ----------------------------------------------------------------------------

module tb_modular_exponentiation;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ExpBits    = 63;
  localparam int unsigned NumRandom  = 1030;
  localparam int unsigned DrainCyc   = 80;
  localparam logic [63:0] PrimeWide  = 64'(mexp_pkg::Prime);
  localparam logic [62:0] Prime63    = 63'(mexp_pkg::Prime);
  localparam logic [62:0] AllOnes    = {63{1'b1}};

  // one row of the directed table; known marks a result typed in by hand
  typedef struct packed {
    logic [mexp_pkg::BaseW-1:0] base;
    logic [62:0]                exponent;
    logic                       known;
    logic [mexp_pkg::ResW-1:0]  result;
  } stim_row_t;

  localparam int unsigned NumDirected = 20;

  stim_row_t directed_rows [NumDirected] = '{
    // first word after reset; zero to the zero is one
    '{63'd0,              63'd0,              1'b1, 30'd1},
    '{63'd0,              63'd1,              1'b1, 30'd0},
    '{63'd0,              AllOnes,            1'b1, 30'd0},
    '{AllOnes,            63'd0,              1'b1, 30'd1},
    // base that reduces to zero
    '{Prime63,            63'd0,              1'b1, 30'd1},
    '{Prime63,            63'd5,              1'b1, 30'd0},
    '{Prime63 * 63'd2,    63'd7,              1'b1, 30'd0},
    '{63'd1,              AllOnes,            1'b1, 30'd1},
    '{Prime63 + 63'd1,    AllOnes,            1'b1, 30'd1},
    '{63'd3,              63'd1,              1'b1, 30'd3},
    '{63'd2,              63'd10,             1'b1, 30'd1024},
    // minus one squared and cubed
    '{Prime63 - 63'd1,    63'd2,              1'b1, 30'd1},
    '{Prime63 - 63'd1,    63'd3,              1'b1, mexp_pkg::Prime - 30'd1},
    // Fermat: a^(p-1) = 1
    '{63'd12345,          Prime63 - 63'd1,    1'b1, 30'd1},
    '{AllOnes,            AllOnes,            1'b0, 30'd0},
    '{63'd7,              63'h4000_0000_0000_0000, 1'b0, 30'd0},
    '{63'h4000_0000_0000_0000, 63'h3FFF_FFFF_FFFF_FFFF, 1'b0, 30'd0},
    '{63'h5555_5555_5555_5555, 63'h2AAA_AAAA_AAAA_AAAA, 1'b0, 30'd0},
    '{63'h2AAA_AAAA_AAAA_AAAA, 63'h5555_5555_5555_5555, 1'b0, 30'd0},
    '{63'd2,              63'd62,             1'b0, 30'd0}
  };

  logic                       clk_i;
  logic                       rst_ni;
  logic                       start;
  logic                       busy;
  logic [mexp_pkg::BaseW-1:0] base_value_i;
  logic [62:0]                exponent_i;
  logic                       done_o;
  logic [mexp_pkg::ResW-1:0]  result_o;

  logic [mexp_pkg::ResW-1:0]  pending_powers [$];
  int unsigned                fail_count;
  int unsigned                burst_left;

  modular_exponentiation #(
    .EXP_BITS(ExpBits)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .base_value_i(base_value_i),
    .exponent_i  (exponent_i),
    .done_o      (done_o),
    .result_o    (result_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // right-to-left square-and-multiply; operands stay below 2^30
  function automatic logic [mexp_pkg::ResW-1:0] pow_mod_prime(
      logic [mexp_pkg::BaseW-1:0] base, logic [62:0] exponent);
    logic [63:0] square;
    logic [63:0] product;
    square  = {1'b0, base} % PrimeWide;
    product = 64'd1;
    for (int i = 0; i < ExpBits; i++) begin
      if (exponent[i]) product = (product * square) % PrimeWide;
      square = (square * square) % PrimeWide;
    end
    return product[mexp_pkg::ResW-1:0];
  endfunction

  function automatic logic [62:0] rand63();
    return 63'({$urandom, $urandom});
  endfunction

  // gap before the next word; occasional runs of back-to-back words
  function automatic int unsigned next_gap();
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    if ($urandom_range(0, 9) == 0) begin
      burst_left = $urandom_range(5, 30);
      return 0;
    end
    return $urandom_range(0, 16);
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic issue_word(logic [mexp_pkg::BaseW-1:0] base, logic [62:0] exponent,
                            logic [mexp_pkg::ResW-1:0] power);
    int unsigned gap;
    gap = next_gap();
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start        = 1'b1;
    base_value_i = base;
    exponent_i   = exponent;
    // busy only moves on rising edges, so its value here holds for the next one
    while (busy) @(negedge clk_i);
    pending_powers.push_back(power);
    @(negedge clk_i);
  endtask

  // results are strobed for one cycle; sample the pre-edge value
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_powers.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %0d", $time, result_o);
        fail_count++;
      end else begin
        if (result_o !== pending_powers[0]) begin
          $display("%0t: result mismatch, expected %0d, actual %0d",
                   $time, pending_powers[0], result_o);
          fail_count++;
        end
        void'(pending_powers.pop_front());
      end
    end
  end

  initial begin
    logic [mexp_pkg::BaseW-1:0] base;
    logic [62:0]                exponent;
    int unsigned                pick;
    int unsigned                len;
    fail_count   = 0;
    burst_left   = 0;
    rst_ni       = 1'b0;
    start        = 1'b0;
    base_value_i = '0;
    exponent_i   = '0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < NumDirected; i++) begin
      issue_word(directed_rows[i].base, directed_rows[i].exponent,
                 directed_rows[i].known ? directed_rows[i].result
                 : pow_mod_prime(directed_rows[i].base, directed_rows[i].exponent));
    end

    for (int i = 0; i < NumRandom; i++) begin
      // base: mostly full width, some small, some near multiples of the prime
      pick = $urandom_range(0, 9);
      if (pick < 8) begin
        base = rand63();
      end else if (pick == 8) begin
        base = 63'($urandom_range(0, 16));
      end else begin
        base = 63'($urandom_range(0, 1000)) * Prime63 + 63'($urandom_range(0, 2)) - 63'd1;
      end
      // exponent: mostly short to keep latency low, a tenth full width
      pick = $urandom_range(0, 19);
      if (pick < 2) begin
        exponent = rand63();
      end else if (pick == 2) begin
        exponent = '0;
      end else begin
        len      = $urandom_range(1, 8);
        exponent = rand63() & ((63'd1 << len) - 63'd1);
      end
      issue_word(base, exponent, pow_mod_prime(base, exponent));
    end
    start = 1'b0;

    wait (pending_powers.size() == 0);
    // stray strobes after the last result would show up here
    repeat (DrainCyc) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // slowest correct run is about 18 ms; allow several times that
  initial begin
    #80_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
